FILE: sv/dsm_pkg.sv
`timescale 1ns / 1ps
// shared constants and width helpers for the disc to square elliptical map
// no dependencies; used by every module of the block except dsm_sqrt
package dsm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int FIELD_W       = 16;
    localparam int PROD_W        = 48;
    localparam int FIFO_DEPTH    = 4;

    // 2*sqrt(2) in unsigned q2.30, rounded
    localparam logic [31:0] TWO_SQRT2_Q30 = 32'd3037000500;

    // signed width that holds every radicand 2*one^2 + p^2 - q^2 +- t
    function automatic int rad_width(input int frac);
        int w;
        w = 2 * frac + 4;
        if (w < 33) begin
            w = 33;
        end
        if (w < frac + 20) begin
            w = frac + 20;
        end
        return w;
    endfunction

endpackage

FILE: sv/dsm_fifo.sv
`timescale 1ns / 1ps
// small register queue between the radicand front end and the square root back end
// depends on dsm_pkg for the default depth
module dsm_fifo #(
    parameter int WIDTH = 132,
    parameter int DEPTH = dsm_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

FILE: sv/dsm_sqrt.sv
`timescale 1ns / 1ps
// pipelined floor square root, one root bit per registered stage
// no package dependencies
module dsm_sqrt #(
    parameter int IN_W = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [IN_W-1:0]         i_rad,
    output logic [(IN_W+1)/2-1:0]   o_root
);

    localparam int RT_W  = (IN_W + 1) / 2;
    localparam int PAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 2;

    logic [PAD_W-1:0] r_x    [RT_W];
    logic [REM_W-1:0] r_rem  [RT_W];
    logic [RT_W-1:0]  r_root [RT_W];

    for (genvar s = 0; s < RT_W; s++) begin : g_stage
        logic [PAD_W-1:0] w_x;
        logic [REM_W-1:0] w_rem;
        logic [RT_W-1:0]  w_root;
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_trial;

        if (s == 0) begin : g_first
            assign w_x    = PAD_W'(i_rad);
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_x    = r_x[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
        end

        // bring down the next bit pair and try (root << 2) | 1
        assign w_cur   = {w_rem[REM_W-3:0], w_x[2*(RT_W-1-s)+1 -: 2]};
        assign w_trial = {w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s] <= w_x;
                if (w_cur >= w_trial) begin
                    r_rem[s]  <= w_cur - w_trial;
                    r_root[s] <= {w_root[RT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= w_cur;
                    r_root[s] <= {w_root[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[RT_W-1];

endmodule

FILE: sv/dsm_front.sv
`timescale 1ns / 1ps
// front end: takes disc points, forms the four clamped radicands, pushes them to the queue
// depends on dsm_pkg for widths and the 2*sqrt(2) constant
module dsm_front #(
    parameter int FRAC_BITS = dsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [dsm_pkg::FIELD_W-1:0]     i_disc_u,
    input  logic signed [dsm_pkg::FIELD_W-1:0]     i_disc_v,
    output logic                                   o_push,
    output logic [4*(dsm_pkg::rad_width(FRAC_BITS)-1)-1:0] o_data,
    input  logic                                   i_full
);

    localparam int RAD_W  = dsm_pkg::rad_width(FRAC_BITS);
    localparam int IN_W   = RAD_W - 1;
    localparam int PROD_W = dsm_pkg::PROD_W;
    localparam int FW     = dsm_pkg::FIELD_W;
    localparam int SH     = 30 - FRAC_BITS;
    localparam int TMAG_W = PROD_W - SH;
    localparam int SQ_W   = 2 * FW - 1;
    localparam logic [PROD_W:0]  HALF    = ((PROD_W + 1)'(1) << SH) >> 1;
    localparam logic [RAD_W-1:0] TWO_ONE = RAD_W'(1) << (2 * FRAC_BITS + 1);

    logic en;

    // stage 1: squares and |p| * 2sqrt2
    logic              r1_valid;
    logic              r1_u_neg, r1_v_neg;
    logic [SQ_W-1:0]   r1_uu, r1_vv;
    logic [PROD_W-1:0] r1_tu, r1_tv;

    // stage 2: rounded cross terms and base values
    logic              r2_valid;
    logic              r2_u_neg, r2_v_neg;
    logic [TMAG_W-1:0] r2_tu, r2_tv;
    logic [RAD_W-1:0]  r2_base_x, r2_base_y;

    // stage 3: clamped radicands
    logic              r3_valid;
    logic [IN_W-1:0]   r3_xa, r3_xb, r3_ya, r3_yb;

    logic signed [2*FW-1:0] w_uu, w_vv;
    logic [FW-1:0]          w_u_mag, w_v_mag;
    logic [PROD_W:0]        w_tu_rnd, w_tv_rnd;
    logic [RAD_W-1:0]       w_x_sum, w_x_dif, w_y_sum, w_y_dif;
    logic [RAD_W-1:0]       w_xa, w_xb, w_ya, w_yb;

    assign en      = !r3_valid || !i_full;
    assign o_ready = en;
    assign o_push  = r3_valid && !i_full;
    assign o_data  = {r3_xa, r3_xb, r3_ya, r3_yb};

    assign w_uu    = i_disc_u * i_disc_u;
    assign w_vv    = i_disc_v * i_disc_v;
    assign w_u_mag = i_disc_u[FW-1] ? FW'(-i_disc_u) : FW'(i_disc_u);
    assign w_v_mag = i_disc_v[FW-1] ? FW'(-i_disc_v) : FW'(i_disc_v);

    assign w_tu_rnd = ({1'b0, r1_tu} + HALF) >> SH;
    assign w_tv_rnd = ({1'b0, r1_tv} + HALF) >> SH;

    assign w_x_sum = r2_base_x + RAD_W'(r2_tu);
    assign w_x_dif = r2_base_x - RAD_W'(r2_tu);
    assign w_y_sum = r2_base_y + RAD_W'(r2_tv);
    assign w_y_dif = r2_base_y - RAD_W'(r2_tv);

    // a negative coordinate flips the sign of its cross term
    assign w_xa = r2_u_neg ? w_x_dif : w_x_sum;
    assign w_xb = r2_u_neg ? w_x_sum : w_x_dif;
    assign w_ya = r2_v_neg ? w_y_dif : w_y_sum;
    assign w_yb = r2_v_neg ? w_y_sum : w_y_dif;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u_neg  <= i_disc_u[FW-1];
            r1_v_neg  <= i_disc_v[FW-1];
            r1_uu     <= SQ_W'(w_uu);
            r1_vv     <= SQ_W'(w_vv);
            r1_tu     <= PROD_W'(w_u_mag) * PROD_W'(dsm_pkg::TWO_SQRT2_Q30);
            r1_tv     <= PROD_W'(w_v_mag) * PROD_W'(dsm_pkg::TWO_SQRT2_Q30);

            r2_u_neg  <= r1_u_neg;
            r2_v_neg  <= r1_v_neg;
            r2_tu     <= TMAG_W'(w_tu_rnd);
            r2_tv     <= TMAG_W'(w_tv_rnd);
            r2_base_x <= TWO_ONE + RAD_W'(r1_uu) - RAD_W'(r1_vv);
            r2_base_y <= TWO_ONE + RAD_W'(r1_vv) - RAD_W'(r1_uu);

            // negative radicands clamp to zero
            r3_xa <= w_xa[RAD_W-1] ? '0 : w_xa[IN_W-1:0];
            r3_xb <= w_xb[RAD_W-1] ? '0 : w_xb[IN_W-1:0];
            r3_ya <= w_ya[RAD_W-1] ? '0 : w_ya[IN_W-1:0];
            r3_yb <= w_yb[RAD_W-1] ? '0 : w_yb[IN_W-1:0];
        end
    end

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && i_full) |=> r3_valid)
        else $error("radicand item dropped while queue full");

endmodule

FILE: sv/dsm_back.sv
`timescale 1ns / 1ps
// back end: four pipelined square roots, halved difference, saturation, output register
// depends on dsm_pkg and dsm_sqrt
module dsm_back #(
    parameter int FRAC_BITS = dsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [4*(dsm_pkg::rad_width(FRAC_BITS)-1)-1:0] i_data,
    input  logic                                   i_empty,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [dsm_pkg::FIELD_W-1:0]     o_square_x,
    output logic signed [dsm_pkg::FIELD_W-1:0]     o_square_y
);

    localparam int RAD_W = dsm_pkg::rad_width(FRAC_BITS);
    localparam int IN_W  = RAD_W - 1;
    localparam int RT_W  = (IN_W + 1) / 2;
    localparam int RES_W = RT_W + 1;
    localparam int FW    = dsm_pkg::FIELD_W;
    localparam longint ONE_L    = longint'(1) << FRAC_BITS;
    localparam longint SAT_HI_L = (ONE_L > 32767) ? 32767 : ONE_L;
    localparam longint SAT_LO_L = (ONE_L > 32768) ? -32768 : -ONE_L;
    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(SAT_HI_L);
    localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(SAT_LO_L);

    logic en;
    logic r_vld [RT_W];
    logic r_o_valid;
    logic signed [FW-1:0] r_x, r_y;

    logic [RT_W-1:0] w_xa, w_xb, w_ya, w_yb;
    logic signed [RES_W-1:0] w_dx, w_dy, w_hx, w_hy, w_sx, w_sy;

    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && !i_empty;

    dsm_sqrt #(.IN_W(IN_W)) u_sqrt_xa (
        .i_clk(i_clk), .i_en(en), .i_rad(i_data[4*IN_W-1 -: IN_W]), .o_root(w_xa)
    );
    dsm_sqrt #(.IN_W(IN_W)) u_sqrt_xb (
        .i_clk(i_clk), .i_en(en), .i_rad(i_data[3*IN_W-1 -: IN_W]), .o_root(w_xb)
    );
    dsm_sqrt #(.IN_W(IN_W)) u_sqrt_ya (
        .i_clk(i_clk), .i_en(en), .i_rad(i_data[2*IN_W-1 -: IN_W]), .o_root(w_ya)
    );
    dsm_sqrt #(.IN_W(IN_W)) u_sqrt_yb (
        .i_clk(i_clk), .i_en(en), .i_rad(i_data[IN_W-1 -: IN_W]), .o_root(w_yb)
    );

    assign w_dx = $signed({1'b0, w_xa}) - $signed({1'b0, w_xb});
    assign w_dy = $signed({1'b0, w_ya}) - $signed({1'b0, w_yb});

    // halve, truncating toward zero
    assign w_hx = (w_dx + $signed(RES_W'(w_dx[RES_W-1]))) >>> 1;
    assign w_hy = (w_dy + $signed(RES_W'(w_dy[RES_W-1]))) >>> 1;

    assign w_sx = (w_hx > SAT_HI) ? SAT_HI : ((w_hx < SAT_LO) ? SAT_LO : w_hx);
    assign w_sy = (w_hy > SAT_HI) ? SAT_HI : ((w_hy < SAT_LO) ? SAT_LO : w_hy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RT_W; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= !i_empty;
            for (int s = 1; s < RT_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_o_valid <= r_vld[RT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= FW'(w_sx);
            r_y <= FW'(w_sy);
        end
    end

    assign o_valid    = r_o_valid;
    assign o_square_x = r_x;
    assign o_square_y = r_y;

endmodule

FILE: sv/disc_to_square_elliptical_map.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// disc in   input      i_valid / o_ready  i_disc_u, i_disc_v   (signed q1.14)
// square    output     o_valid / i_ready  o_square_x, o_square_y (signed q1.14)
//
// one item per cycle sustained without backpressure; path: front registers, queue,
// one root stage per root bit ((rad_width-1+1)/2, 17 at 14 fraction bits), output register
// synchronous active-low reset clears valids, queue pointers and count only, no clearing pass
// the front stalls only when the 4-entry queue is full, the back only on output backpressure
module disc_to_square_elliptical_map #(
    parameter int FRAC_BITS = dsm_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [dsm_pkg::FIELD_W-1:0] i_disc_u,
    input  logic signed [dsm_pkg::FIELD_W-1:0] i_disc_v,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [dsm_pkg::FIELD_W-1:0] o_square_x,
    output logic signed [dsm_pkg::FIELD_W-1:0] o_square_y
);

    localparam int Q_W = 4 * (dsm_pkg::rad_width(FRAC_BITS) - 1);

    logic           w_push, w_pop, w_full, w_empty;
    logic [Q_W-1:0] w_wr_data, w_rd_data;

    dsm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_disc_u (i_disc_u),
        .i_disc_v (i_disc_v),
        .o_push   (w_push),
        .o_data   (w_wr_data),
        .i_full   (w_full)
    );

    dsm_fifo #(.WIDTH(Q_W), .DEPTH(dsm_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_wr_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_rd_data),
        .o_empty (w_empty)
    );

    dsm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (w_rd_data),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_square_x (o_square_x),
        .o_square_y (o_square_y)
    );

endmodule
